// ===== hdl/wiegand_frame_transmitter_core_assert.svh =====
// ---------------------------------------------------------------------------
// wiegand frame transmitter assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while in reset
// ---------------------------------------------------------------------------
`ifndef WIEGAND_FRAME_TRANSMITTER_CORE_ASSERT_SVH
`define WIEGAND_FRAME_TRANSMITTER_CORE_ASSERT_SVH

// same-cycle implication
`define WFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wft assertion failed");

// next-cycle implication
`define WFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wft assertion failed");

`endif

// ===== hdl/wft_pkg.sv =====
// ---------------------------------------------------------------------------
// wft_pkg
// shared types and constants of the wiegand frame transmitter
// ---------------------------------------------------------------------------
package wft_pkg;

  // request opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_PULSE_LOW_TICKS = 2'd0;
  localparam logic [1:0] REG_GAP_TICKS       = 2'd1;
  localparam logic [1:0] REG_FRAME_BITS      = 2'd2;
  localparam logic [1:0] REG_KEEP_FACILITY   = 2'd3;

  // configuration reset values
  localparam logic [15:0] PULSE_LOW_TICKS_RST = 16'd100;
  localparam logic [15:0] GAP_TICKS_RST       = 16'd2000;
  localparam logic [6:0]  FRAME_BITS_RST      = 7'd26;
  localparam logic        KEEP_FACILITY_RST   = 1'b1;

  // frame shape
  localparam logic [6:0] FRAME_BITS_MIN = 7'd10;
  localparam logic [6:0] PARITY_BITS    = 7'd2;
  localparam logic [6:0] FACILITY_BITS  = 7'd8;

  localparam int CARD_W = 62;

  // one result item
  typedef struct packed {
    logic d0_line;
    logic d1_line;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

  // timing configuration handed to the sequencer
  typedef struct packed {
    logic [15:0] pulse_low_ticks;
    logic [15:0] gap_ticks;
  } timing_t;

endpackage

// ===== hdl/wft_frame_build.sv =====
// ---------------------------------------------------------------------------
// wft_frame_build
// builds the parity-wrapped frame and its length from a send request
// ---------------------------------------------------------------------------
module wft_frame_build #(
  parameter int MAX_FRAME_BITS = 64
) (
  input  logic [wft_pkg::CARD_W-1:0]          card_data,
  input  logic [6:0]                          frame_bits,
  input  logic                                keep_facility,
  output logic [MAX_FRAME_BITS-1:0]           frame,
  output logic [$clog2(MAX_FRAME_BITS+1)-1:0] frame_len
);

  localparam int FW = MAX_FRAME_BITS;
  localparam int DW = MAX_FRAME_BITS - 2;
  localparam int CW = $clog2(MAX_FRAME_BITS + 1);

  logic [6:0]    fb_sat;
  logic [6:0]    n_data;
  logic [6:0]    n_fac;
  logic [6:0]    n_half;
  logic [DW-1:0] ones;
  logic [DW-1:0] data;
  logic [DW-1:0] low_part;
  logic [DW-1:0] high_part;
  logic          par_odd;
  logic          par_even;

  // saturate length into the legal range
  always_comb begin
    if (frame_bits < wft_pkg::FRAME_BITS_MIN) begin
      fb_sat = wft_pkg::FRAME_BITS_MIN;
    end else if (frame_bits > 7'(MAX_FRAME_BITS)) begin
      fb_sat = 7'(MAX_FRAME_BITS);
    end else begin
      fb_sat = frame_bits;
    end
  end

  assign n_data = fb_sat - wft_pkg::PARITY_BITS;
  assign n_fac  = n_data - wft_pkg::FACILITY_BITS;
  assign n_half = {1'b0, n_data[6:1]};
  assign ones   = {DW{1'b1}};

  // data bits, optionally without the facility byte
  always_comb begin
    data = card_data[DW-1:0] & ~(ones << n_data);
    if (!keep_facility) begin
      data = data & ~(ones << n_fac);
    end
  end

  // parity halves: lower half odd, upper half even
  assign low_part  = data & ~(ones << n_half);
  assign high_part = data >> n_half;
  assign par_odd   = ~(^low_part);
  assign par_even  = ^high_part;

  // even parity leads, odd parity trails
  assign frame     = (FW'(par_even) << (n_data + 7'd1)) | {1'b0, data, par_odd};
  assign frame_len = CW'(fb_sat);

endmodule

// ===== hdl/wft_seq.sv =====
// ---------------------------------------------------------------------------
// wft_seq
// pulse and gap sequencer with the result register
// ---------------------------------------------------------------------------
module wft_seq #(
  parameter int MAX_FRAME_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [MAX_FRAME_BITS-1:0]           load_frame,
  input  logic [$clog2(MAX_FRAME_BITS+1)-1:0] load_len,
  input  wft_pkg::timing_t                    timing,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wft_pkg::result_t                    result
);

  localparam int FW = MAX_FRAME_BITS;
  localparam int CW = $clog2(MAX_FRAME_BITS + 1);
  localparam int IW = $clog2(MAX_FRAME_BITS);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [CW-1:0]    bits_r, bits_nxt;
  logic [FW-1:0]    frame_r, frame_nxt;
  logic             out_valid_r, out_valid_nxt;
  wft_pkg::result_t res_r, res_nxt;

  logic          accept;
  logic          busy;
  logic [15:0]   timer_dec;
  logic [15:0]   pulse_eff;
  logic [15:0]   gap_eff;
  logic [CW-1:0] bits_dec;
  logic [CW-1:0] bit_sel;
  logic [IW-1:0] bit_idx;
  logic          cur_bit;

  // output register frees up as it drains
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign busy      = (phase_r == PH_LOW) || (phase_r == PH_GAP);
  assign timer_dec = timer_r - 16'd1;
  assign pulse_eff = (timing.pulse_low_ticks == 16'd0) ? 16'd1 : timing.pulse_low_ticks;
  assign gap_eff   = (timing.gap_ticks == 16'd0) ? 16'd1 : timing.gap_ticks;
  assign bits_dec  = (bits_r != '0) ? bits_r - CW'(1) : bits_r;

  // next state and result
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    bits_nxt  = bits_r;
    frame_nxt = frame_r;
    res_nxt   = res_r;
    bit_sel   = '0;
    bit_idx   = '0;
    cur_bit   = 1'b0;

    if (accept) begin
      res_nxt = '{d0_line: 1'b1, d1_line: 1'b1, busy_res: 1'b0,
                  frame_done: 1'b0, rejected: 1'b0};

      if (in_opcode == wft_pkg::OP_SEND) begin
        if (busy) begin
          res_nxt.rejected = 1'b1;
        end else begin
          frame_nxt = load_frame;
          bits_nxt  = load_len;
          phase_nxt = PH_LOW;
          timer_nxt = pulse_eff;
        end
      end else begin
        unique case (phase_r)
          PH_LOW: begin
            timer_nxt = timer_dec;
            if (timer_dec == 16'd0) begin
              phase_nxt = PH_GAP;
              timer_nxt = gap_eff;
            end
          end
          PH_GAP: begin
            timer_nxt = timer_dec;
            if (timer_dec == 16'd0) begin
              bits_nxt = bits_dec;
              if (bits_dec == '0) begin
                phase_nxt          = PH_IDLE;
                res_nxt.frame_done = 1'b1;
              end else begin
                phase_nxt = PH_LOW;
                timer_nxt = pulse_eff;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // line levels from the bit now being pulsed
      bit_sel = bits_nxt - CW'(1);
      bit_idx = bit_sel[IW-1:0];
      cur_bit = frame_nxt[bit_idx];
      if (phase_nxt == PH_LOW && bits_nxt != '0) begin
        if (cur_bit) begin
          res_nxt.d1_line = 1'b0;
        end else begin
          res_nxt.d0_line = 1'b0;
        end
      end
      res_nxt.busy_res = (phase_nxt == PH_LOW) || (phase_nxt == PH_GAP);
    end
  end

  // result valid tracking
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      bits_r      <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bits_r      <= bits_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

// ===== hdl/wiegand_frame_transmitter_core.sv =====
// ---------------------------------------------------------------------------
// wiegand_frame_transmitter_core
// wiegand d0/d1 frame transmitter driven by tick and send requests
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready): one request per item, in_opcode tick
//   advances time by one tick, in_opcode send loads in_card_data and starts
//   a frame. every request yields exactly one result on the out_ channel.
//   result channel (out_valid/out_ready): line levels after the request,
//   busy, frame done and rejected flags.
//   out_valid rises in the cycle after accept; one request per cycle is
//   taken while the result register drains; a single state update lies
//   between the request and the result register.
//   if the receiver stalls, the pending result holds and in_ready drops
//   until it is taken; no request is lost or repeated. reset (rst_n low,
//   synchronous) returns to idle, clears the result, leaves none pending and
//   loads default timing and frame length. the user writes configuration via
//   cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not check.
// ---------------------------------------------------------------------------
module wiegand_frame_transmitter_core #(
  parameter int MAX_FRAME_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [wft_pkg::CARD_W-1:0] in_card_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_d0_line,
  output logic                       out_d1_line,
  output logic                       out_busy_res,
  output logic                       out_frame_done,
  output logic                       out_rejected,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [15:0]                cfg_wdata
);

  localparam int CW = $clog2(MAX_FRAME_BITS + 1);

  logic [15:0] pulse_low_ticks_r;
  logic [15:0] gap_ticks_r;
  logic [6:0]  frame_bits_r;
  logic        keep_facility_r;

  logic [MAX_FRAME_BITS-1:0] load_frame;
  logic [CW-1:0]             load_len;
  wft_pkg::timing_t          timing;
  wft_pkg::result_t          result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_low_ticks_r <= wft_pkg::PULSE_LOW_TICKS_RST;
      gap_ticks_r       <= wft_pkg::GAP_TICKS_RST;
      frame_bits_r      <= wft_pkg::FRAME_BITS_RST;
      keep_facility_r   <= wft_pkg::KEEP_FACILITY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wft_pkg::REG_PULSE_LOW_TICKS: pulse_low_ticks_r <= cfg_wdata;
        wft_pkg::REG_GAP_TICKS:       gap_ticks_r       <= cfg_wdata;
        wft_pkg::REG_FRAME_BITS:      frame_bits_r      <= cfg_wdata[6:0];
        wft_pkg::REG_KEEP_FACILITY:   keep_facility_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign timing = '{pulse_low_ticks: pulse_low_ticks_r, gap_ticks: gap_ticks_r};

  // frame assembly
  wft_frame_build #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_build (
    .card_data    (in_card_data),
    .frame_bits   (frame_bits_r),
    .keep_facility(keep_facility_r),
    .frame        (load_frame),
    .frame_len    (load_len)
  );

  // sequencer and result register
  wft_seq #(
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .load_frame(load_frame),
    .load_len  (load_len),
    .timing    (timing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_d0_line    = result.d0_line;
  assign out_d1_line    = result.d1_line;
  assign out_busy_res   = result.busy_res;
  assign out_frame_done = result.frame_done;
  assign out_rejected   = result.rejected;

endmodule

// ===== hdl/wft_checker.sv =====
// ---------------------------------------------------------------------------
// wft_checker
// port-level checks of the wiegand frame transmitter, bound to the top level
// ---------------------------------------------------------------------------
`include "wiegand_frame_transmitter_core_assert.svh"

module wft_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_d0_line,
  input logic out_d1_line,
  input logic out_busy_res,
  input logic out_frame_done,
  input logic out_rejected
);

  // a stalled result keeps its line levels and busy flag
  `WFT_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(out_busy_res) && $stable(out_d0_line) && $stable(out_d1_line))

  // only one line is ever pulled low
  `WFT_ASSERT_NOW(a_one_line_low, out_valid, out_d0_line || out_d1_line)

  // both lines idle high outside a frame
  `WFT_ASSERT_NOW(a_idle_high, out_valid && !out_busy_res, out_d0_line && out_d1_line)

  // frame end leaves the transmitter idle
  `WFT_ASSERT_NOW(a_done_idle, out_valid && out_frame_done, !out_busy_res && !out_rejected)

  // a refused send only happens mid-frame
  `WFT_ASSERT_NOW(a_reject_busy, out_valid && out_rejected, out_busy_res)

endmodule

bind wiegand_frame_transmitter_core wft_checker u_wft_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_d0_line   (out_d0_line),
  .out_d1_line   (out_d1_line),
  .out_busy_res  (out_busy_res),
  .out_frame_done(out_frame_done),
  .out_rejected  (out_rejected)
);
